@@ rtl/core/itgc_pkg.sv @@
// Package for the IMU tilt and gravity compensation block.
// Holds the shared widths, fixed-point constants, register codes and CORDIC helpers.
// No dependencies.
package itgc_pkg;

    // Default number of CORDIC iterations
    localparam int CORDIC_STAGES_DEF = 16;

    // Datapath widths
    localparam int ANG_W = 16;  // Q3.13 angle
    localparam int ROT_W = 34;  // rotation CORDIC x/y/z
    localparam int VEC_W = 36;  // vectoring CORDIC x/y/z
    localparam int SC_W  = 32;  // Q1.30 sine/cosine and matrix products

    // Fixed-point constants
    localparam logic signed [16:0]      PI_Q13      = 17'sd25736;
    localparam logic signed [16:0]      HALF_PI_Q13 = 17'sd12868;
    localparam logic signed [VEC_W-1:0] PI_Q30      = 36'sd3373259426;
    localparam logic signed [ROT_W-1:0] KGAIN_Q30   = 34'sd652032874;
    localparam logic signed [VEC_W-1:0] ANGLE_LIMIT = 36'sd25736;

    // Register reset values
    localparam logic [15:0] BLEND_RESET   = 16'd64225;
    localparam logic [14:0] GRAVITY_RESET = 15'd5023;

    // Register index (word address bit 2)
    typedef enum logic {
        REG_BLEND_WEIGHT   = 1'b0,
        REG_GRAVITY_OFFSET = 1'b1
    } t_reg_idx;

    // Sine and cosine pair, Q1.30
    typedef struct packed {
        logic signed [SC_W-1:0] cos_v;
        logic signed [SC_W-1:0] sin_v;
    } t_sincos;

    // atan(2^-i) in units of 2^-30 rad
    function automatic logic signed [VEC_W-1:0] atan_step(input int i);
        logic signed [VEC_W-1:0] v;
        v = '0;
        case (i)
            0:       v = 36'sh03243F6A9;
            1:       v = 36'sh01DAC6705;
            2:       v = 36'sh00FADBAFD;
            3:       v = 36'sh007F56EA7;
            4:       v = 36'sh003FEAB77;
            5:       v = 36'sh001FFD55C;
            6:       v = 36'sh000FFFAAB;
            7:       v = 36'sh0007FFF55;
            8:       v = 36'sh0003FFFEB;
            9:       v = 36'sh0001FFFFD;
            default: begin
                if (i <= 30) begin
                    v[30-i] = 1'b1;
                end
            end
        endcase
        return v;
    endfunction

    // Q1.30 product, rounded to nearest (half up)
    function automatic logic signed [SC_W-1:0] mul30(input logic signed [SC_W-1:0] a,
                                                     input logic signed [SC_W-1:0] b);
        logic signed [63:0] p;
        p = 64'(a) * 64'(b);
        return SC_W'((p + 64'sd536870912) >>> 30);
    endfunction

endpackage

@@ rtl/core/imu_tilt_gravity_compensation.sv @@
// IMU tilt and gravity compensation, top level. Depends on itgc_pkg, itgc_rotator, itgc_vectorer.
// The latency is set by the square root
// pipeline (30 stages) feeding the pitch vectoring CORDIC, then the blend.
// Throughput: one transfer per cycle; the whole pipeline holds while the output waits.
// Reset (synchronous, active low) clears the valid bits and loads register defaults.
module imu_tilt_gravity_compensation #(
    parameter int CORDIC_STAGES = itgc_pkg::CORDIC_STAGES_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // stream in
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // roll, pitch, yaw, accel_x, accel_y, accel_z (16 bits each, from bit 0)
    input  logic [95:0]  s_axis_tdata,
    // stream out
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // inertial_x[16:0], inertial_y[33:17], inertial_z[51:34], tilt_roll[67:52],
    // tilt_pitch[83:68], heading_from_accel[99:84], filtered_roll[115:100],
    // filtered_pitch[131:116], zero fill [135:132]
    output logic [135:0] m_axis_tdata,
    // configuration
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import itgc_pkg::*;

    localparam int LAT     = CORDIC_STAGES + 36;
    localparam int ISQ_N   = 30;
    localparam int D_PROP  = CORDIC_STAGES + 33;
    localparam int D_AXP   = 31;
    localparam int D_ACC   = CORDIC_STAGES + 4;
    localparam int D_TILT  = 31;
    localparam int D_INRT  = 27;

    logic en;

    // ---------------- configuration registers ----------------
    logic [15:0] r_blend_weight;
    logic [14:0] r_gravity_offset;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blend_weight   <= BLEND_RESET;
            r_gravity_offset <= GRAVITY_RESET;
        end else if (psel && penable && pwrite) begin
            case (t_reg_idx'(paddr[2]))
                REG_BLEND_WEIGHT:   r_blend_weight   <= pwdata[15:0];
                REG_GRAVITY_OFFSET: r_gravity_offset <= pwdata[14:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (t_reg_idx'(paddr[2]))
            REG_BLEND_WEIGHT:   prdata = {16'd0, r_blend_weight};
            REG_GRAVITY_OFFSET: prdata = {17'd0, r_gravity_offset};
            default:            prdata = '0;
        endcase
    end

    // ---------------- valid chain and flow control ----------------
    logic [LAT-1:0] r_vld;

    assign en            = !r_vld[LAT-1] || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], s_axis_tvalid};
        end
    end

    // ---------------- input stage ----------------
    logic signed [15:0] r_in_roll, r_in_pitch, r_in_yaw;
    logic signed [15:0] r_in_ax, r_in_ay, r_in_az;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_in_roll  <= s_axis_tdata[15:0];
            r_in_pitch <= s_axis_tdata[31:16];
            r_in_yaw   <= s_axis_tdata[47:32];
            r_in_ax    <= s_axis_tdata[63:48];
            r_in_ay    <= s_axis_tdata[79:64];
            r_in_az    <= s_axis_tdata[95:80];
        end
    end

    // ---------------- sine/cosine of the propagated angles ----------------
    t_sincos sc_roll, sc_pitch, sc_yaw;

    itgc_rotator #(.STAGES(CORDIC_STAGES)) u_rot_roll (
        .i_clk(i_clk), .i_en(en), .i_angle(r_in_roll), .o_sc(sc_roll));
    itgc_rotator #(.STAGES(CORDIC_STAGES)) u_rot_pitch (
        .i_clk(i_clk), .i_en(en), .i_angle(r_in_pitch), .o_sc(sc_pitch));
    itgc_rotator #(.STAGES(CORDIC_STAGES)) u_rot_yaw (
        .i_clk(i_clk), .i_en(en), .i_angle(r_in_yaw), .o_sc(sc_yaw));

    // ---------------- accelerometer roll and heading ----------------
    logic signed [VEC_W-1:0] vx_roll, vy_ay, vx_head;
    logic signed [15:0]      tilt_roll_w, tilt_head_w, tilt_pitch_w;

    assign vy_ay   = VEC_W'(r_in_ay) <<< 14;
    assign vx_roll = VEC_W'(r_in_az) <<< 14;
    assign vx_head = VEC_W'(r_in_ax) <<< 14;

    itgc_vectorer #(.STAGES(CORDIC_STAGES)) u_vec_roll (
        .i_clk(i_clk), .i_en(en), .i_x(vx_roll), .i_y(vy_ay), .o_angle(tilt_roll_w));
    itgc_vectorer #(.STAGES(CORDIC_STAGES)) u_vec_head (
        .i_clk(i_clk), .i_en(en), .i_x(vx_head), .i_y(vy_ay), .o_angle(tilt_head_w));

    // ---------------- ay^2 + az^2 ----------------
    logic signed [31:0] sq_y, sq_z;
    logic [31:0]        r_sq;

    assign sq_y = 32'(r_in_ay) * 32'(r_in_ay);
    assign sq_z = 32'(r_in_az) * 32'(r_in_az);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sq <= $unsigned(sq_y) + $unsigned(sq_z);
        end
    end

    // ---------------- integer square root, one result bit per stage ----------------
    logic [59:0] r_sv [ISQ_N];
    logic [59:0] r_sr [ISQ_N];

    for (genvar k = 0; k < ISQ_N; k++) begin : g_isq
        localparam logic [60:0] BIT = 61'(1) << (58 - 2 * k);
        logic [59:0] v_i, r_i;
        logic [60:0] trial;
        if (k == 0) begin : g_first
            assign v_i = {r_sq, 28'd0};
            assign r_i = '0;
        end else begin : g_next
            assign v_i = r_sv[k-1];
            assign r_i = r_sr[k-1];
        end
        assign trial = {1'b0, r_i} + BIT;
        always_ff @(posedge i_clk) begin
            if (en) begin
                if ({1'b0, v_i} >= trial) begin
                    r_sv[k] <= v_i - trial[59:0];
                    r_sr[k] <= (r_i >> 1) + BIT[59:0];
                end else begin
                    r_sv[k] <= v_i;
                    r_sr[k] <= r_i >> 1;
                end
            end
        end
    end

    // ax aligned with the root
    logic signed [15:0] r_d_axp [D_AXP];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d_axp[0] <= r_in_ax;
            for (int k = 1; k < D_AXP; k++) r_d_axp[k] <= r_d_axp[k-1];
        end
    end

    // ---------------- accelerometer pitch ----------------
    logic signed [VEC_W-1:0] vx_pitch, vy_pitch;

    assign vx_pitch = VEC_W'({6'd0, r_sr[ISQ_N-1][29:0]});
    assign vy_pitch = (-VEC_W'(r_d_axp[D_AXP-1])) <<< 14;

    itgc_vectorer #(.STAGES(CORDIC_STAGES)) u_vec_pitch (
        .i_clk(i_clk), .i_en(en), .i_x(vx_pitch), .i_y(vy_pitch), .o_angle(tilt_pitch_w));

    // ---------------- rotation matrix, first products ----------------
    logic signed [SC_W-1:0] r_sxsy, r_cxsy, r_cycz, r_cxsz, r_sxsz;
    logic signed [SC_W-1:0] r_cysz, r_cxcz, r_sxcz, r_sxcy, r_cxcy;
    logic signed [SC_W-1:0] r_m1_cz, r_m1_sz, r_m1_sy;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sxsy  <= mul30(sc_roll.sin_v, sc_pitch.sin_v);
            r_cxsy  <= mul30(sc_roll.cos_v, sc_pitch.sin_v);
            r_cycz  <= mul30(sc_pitch.cos_v, sc_yaw.cos_v);
            r_cxsz  <= mul30(sc_roll.cos_v, sc_yaw.sin_v);
            r_sxsz  <= mul30(sc_roll.sin_v, sc_yaw.sin_v);
            r_cysz  <= mul30(sc_pitch.cos_v, sc_yaw.sin_v);
            r_cxcz  <= mul30(sc_roll.cos_v, sc_yaw.cos_v);
            r_sxcz  <= mul30(sc_roll.sin_v, sc_yaw.cos_v);
            r_sxcy  <= mul30(sc_roll.sin_v, sc_pitch.cos_v);
            r_cxcy  <= mul30(sc_roll.cos_v, sc_pitch.cos_v);
            r_m1_cz <= sc_yaw.cos_v;
            r_m1_sz <= sc_yaw.sin_v;
            r_m1_sy <= sc_pitch.sin_v;
        end
    end

    // ---------------- rotation matrix entries ----------------
    logic signed [32:0] r_m00, r_m10, r_m20, r_m01, r_m11, r_m21, r_m02, r_m12, r_m22;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m00 <= 33'(r_cycz);
            r_m10 <= 33'(mul30(r_sxsy, r_m1_cz)) - 33'(r_cxsz);
            r_m20 <= 33'(mul30(r_cxsy, r_m1_cz)) + 33'(r_sxsz);
            r_m01 <= 33'(r_cysz);
            r_m11 <= 33'(mul30(r_sxsy, r_m1_sz)) + 33'(r_cxcz);
            r_m21 <= 33'(mul30(r_cxsy, r_m1_sz)) - 33'(r_sxcz);
            r_m02 <= -33'(r_m1_sy);
            r_m12 <= 33'(r_sxcy);
            r_m22 <= 33'(r_cxcy);
        end
    end

    // accelerations aligned with the matrix
    logic [47:0] r_d_acc [D_ACC];
    logic signed [15:0] ax_m, ay_m, az_m;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d_acc[0] <= {r_in_az, r_in_ay, r_in_ax};
            for (int k = 1; k < D_ACC; k++) r_d_acc[k] <= r_d_acc[k-1];
        end
    end

    assign ax_m = r_d_acc[D_ACC-1][15:0];
    assign ay_m = r_d_acc[D_ACC-1][31:16];
    assign az_m = r_d_acc[D_ACC-1][47:32];

    // ---------------- R transpose times acceleration ----------------
    logic signed [48:0] r_p00, r_p10, r_p20, r_p01, r_p11, r_p21, r_p02, r_p12, r_p22;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p00 <= 49'(r_m00) * 49'(ax_m);
            r_p10 <= 49'(r_m10) * 49'(ay_m);
            r_p20 <= 49'(r_m20) * 49'(az_m);
            r_p01 <= 49'(r_m01) * 49'(ax_m);
            r_p11 <= 49'(r_m11) * 49'(ay_m);
            r_p21 <= 49'(r_m21) * 49'(az_m);
            r_p02 <= 49'(r_m02) * 49'(ax_m);
            r_p12 <= 49'(r_m12) * 49'(ay_m);
            r_p22 <= 49'(r_m22) * 49'(az_m);
        end
    end

    // ---------------- row sums, rounding, gravity, saturation ----------------
    logic signed [51:0] n_rx, n_ry, n_rz;
    logic signed [16:0] n_ix, n_iy;
    logic signed [17:0] n_iz;
    logic [51:0]        r_inrt;

    always_comb begin
        n_rx = (52'(r_p00) + 52'(r_p10) + 52'(r_p20) + 52'sd536870912) >>> 30;
        n_ry = (52'(r_p01) + 52'(r_p11) + 52'(r_p21) + 52'sd536870912) >>> 30;
        n_rz = ((52'(r_p02) + 52'(r_p12) + 52'(r_p22) + 52'sd536870912) >>> 30)
               - 52'($signed({1'b0, r_gravity_offset}));
        if (n_rx > 52'sd65535)       n_ix = 17'sd65535;
        else if (n_rx < -52'sd65536) n_ix = -17'sd65536;
        else                         n_ix = 17'(n_rx);
        if (n_ry > 52'sd65535)       n_iy = 17'sd65535;
        else if (n_ry < -52'sd65536) n_iy = -17'sd65536;
        else                         n_iy = 17'(n_ry);
        if (n_rz > 52'sd131071)       n_iz = 18'sd131071;
        else if (n_rz < -52'sd131072) n_iz = -18'sd131072;
        else                          n_iz = 18'(n_rz);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_inrt <= {n_iz, n_iy, n_ix};
        end
    end

    // ---------------- alignment to the pitch result ----------------
    logic [51:0] r_d_inrt [D_INRT];
    logic [31:0] r_d_tilt [D_TILT];
    logic [31:0] r_d_prop [D_PROP];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d_inrt[0] <= r_inrt;
            for (int k = 1; k < D_INRT; k++) r_d_inrt[k] <= r_d_inrt[k-1];
            r_d_tilt[0] <= {tilt_head_w, tilt_roll_w};
            for (int k = 1; k < D_TILT; k++) r_d_tilt[k] <= r_d_tilt[k-1];
            r_d_prop[0] <= {r_in_pitch, r_in_roll};
            for (int k = 1; k < D_PROP; k++) r_d_prop[k] <= r_d_prop[k-1];
        end
    end

    // ---------------- blend products ----------------
    logic signed [33:0] w_s, wc_s;
    logic signed [33:0] r_b_pr, r_b_tr, r_b_pp, r_b_tp;
    logic [51:0]        r_b_inrt;
    logic signed [15:0] r_b_troll, r_b_tpitch, r_b_head;

    assign w_s  = 34'($signed({1'b0, r_blend_weight}));
    assign wc_s = 34'sd65536 - w_s;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_pr     <= w_s  * 34'($signed(r_d_prop[D_PROP-1][15:0]));
            r_b_tr     <= wc_s * 34'($signed(r_d_tilt[D_TILT-1][15:0]));
            r_b_pp     <= w_s  * 34'($signed(r_d_prop[D_PROP-1][31:16]));
            r_b_tp     <= wc_s * 34'(tilt_pitch_w);
            r_b_inrt   <= r_d_inrt[D_INRT-1];
            r_b_troll  <= r_d_tilt[D_TILT-1][15:0];
            r_b_head   <= r_d_tilt[D_TILT-1][31:16];
            r_b_tpitch <= tilt_pitch_w;
        end
    end

    // ---------------- blend sum and output register ----------------
    logic signed [34:0] n_fr, n_fp;
    logic signed [15:0] n_froll, n_fpitch;
    logic [51:0]        r_o_inrt;
    logic signed [15:0] r_o_troll, r_o_tpitch, r_o_head, r_o_froll, r_o_fpitch;

    always_comb begin
        n_fr = (35'(r_b_pr) + 35'(r_b_tr) + 35'sd32768) >>> 16;
        n_fp = (35'(r_b_pp) + 35'(r_b_tp) + 35'sd32768) >>> 16;
        if (n_fr > 35'sd32767)       n_froll = 16'sd32767;
        else if (n_fr < -35'sd32768) n_froll = -16'sd32768;
        else                         n_froll = 16'(n_fr);
        if (n_fp > 35'sd32767)       n_fpitch = 16'sd32767;
        else if (n_fp < -35'sd32768) n_fpitch = -16'sd32768;
        else                         n_fpitch = 16'(n_fp);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_inrt   <= r_b_inrt;
            r_o_troll  <= r_b_troll;
            r_o_tpitch <= r_b_tpitch;
            r_o_head   <= r_b_head;
            r_o_froll  <= n_froll;
            r_o_fpitch <= n_fpitch;
        end
    end

    assign m_axis_tdata = {4'd0, r_o_fpitch, r_o_froll, r_o_head, r_o_tpitch, r_o_troll,
                           r_o_inrt};

    // ---------------- assertions ----------------
    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> r_vld[0])
        else $error("accepted transfer missing from first stage");

    a_stall_freezes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(r_vld))
        else $error("pipeline moved during output stall");

    a_roll_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (r_o_troll <= 16'sd25736) && (r_o_troll >= -16'sd25736))
        else $error("tilt roll out of range");

    a_pitch_head_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (r_o_tpitch <= 16'sd25736) && (r_o_tpitch >= -16'sd25736)
                       && (r_o_head <= 16'sd25736) && (r_o_head >= -16'sd25736))
        else $error("tilt pitch or heading out of range");

endmodule

@@ rtl/core/itgc_rotator.sv @@
// Pipelined rotation-mode CORDIC: sine and cosine of a Q3.13 angle.
// Depends on itgc_pkg. Advances on i_en.
module itgc_rotator #(
    parameter int STAGES = itgc_pkg::CORDIC_STAGES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [15:0]   i_angle,
    output itgc_pkg::t_sincos    o_sc
);
    import itgc_pkg::*;

    logic signed [ROT_W-1:0] r_x [STAGES+1];
    logic signed [ROT_W-1:0] r_y [STAGES+1];
    logic signed [ROT_W-1:0] r_z [STAGES+1];
    logic                    r_flip [STAGES+1];
    t_sincos                 r_sc;

    logic signed [16:0]      n_a;
    logic                    n_flip;

    // Fold the angle into the right half plane
    always_comb begin
        n_a    = {i_angle[15], i_angle};
        n_flip = 1'b0;
        if (n_a > HALF_PI_Q13) begin
            n_a    = n_a - PI_Q13;
            n_flip = 1'b1;
        end else if (n_a < -HALF_PI_Q13) begin
            n_a    = n_a + PI_Q13;
            n_flip = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]    <= KGAIN_Q30;
            r_y[0]    <= '0;
            r_z[0]    <= ROT_W'(n_a) <<< 17;
            r_flip[0] <= n_flip;
        end
    end

    // One micro-rotation per stage
    for (genvar g = 0; g < STAGES; g++) begin : g_iter
        localparam logic signed [ROT_W-1:0] ATAN = ROT_W'(atan_step(g));
        logic signed [ROT_W-1:0] dx;
        logic signed [ROT_W-1:0] dy;
        assign dx = r_y[g] >>> g;
        assign dy = r_x[g] >>> g;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!r_z[g][ROT_W-1]) begin
                    r_x[g+1] <= r_x[g] - dx;
                    r_y[g+1] <= r_y[g] + dy;
                    r_z[g+1] <= r_z[g] - ATAN;
                end else begin
                    r_x[g+1] <= r_x[g] + dx;
                    r_y[g+1] <= r_y[g] - dy;
                    r_z[g+1] <= r_z[g] + ATAN;
                end
                r_flip[g+1] <= r_flip[g];
            end
        end
    end

    // Undo the fold
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sc.cos_v <= r_flip[STAGES] ? SC_W'(-r_x[STAGES]) : SC_W'(r_x[STAGES]);
            r_sc.sin_v <= r_flip[STAGES] ? SC_W'(-r_y[STAGES]) : SC_W'(r_y[STAGES]);
        end
    end

    assign o_sc = r_sc;

endmodule

@@ rtl/core/itgc_vectorer.sv @@
// Pipelined vectoring-mode CORDIC: atan2(y, x) rounded to Q3.13 and clamped to +-pi.
// Depends on itgc_pkg. Advances on i_en.
module itgc_vectorer #(
    parameter int STAGES = itgc_pkg::CORDIC_STAGES_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  logic signed [itgc_pkg::VEC_W-1:0]  i_x,
    input  logic signed [itgc_pkg::VEC_W-1:0]  i_y,
    output logic signed [15:0]                 o_angle
);
    import itgc_pkg::*;

    logic signed [VEC_W-1:0] r_x [STAGES+1];
    logic signed [VEC_W-1:0] r_y [STAGES+1];
    logic signed [VEC_W-1:0] r_z [STAGES+1];
    logic                    r_zero [STAGES+1];
    logic signed [15:0]      r_angle;

    logic signed [VEC_W-1:0] n_rnd;

    // Left half plane: negate and start at +-pi
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_zero[0] <= (i_x == '0) && (i_y == '0);
            if (i_x[VEC_W-1]) begin
                r_z[0] <= i_y[VEC_W-1] ? -PI_Q30 : PI_Q30;
                r_x[0] <= -i_x;
                r_y[0] <= -i_y;
            end else begin
                r_z[0] <= '0;
                r_x[0] <= i_x;
                r_y[0] <= i_y;
            end
        end
    end

    // Drive y toward zero, one step per stage
    for (genvar g = 0; g < STAGES; g++) begin : g_iter
        localparam logic signed [VEC_W-1:0] ATAN = atan_step(g);
        logic signed [VEC_W-1:0] dx;
        logic signed [VEC_W-1:0] dy;
        assign dx = r_y[g] >>> g;
        assign dy = r_x[g] >>> g;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!r_y[g][VEC_W-1]) begin
                    r_x[g+1] <= r_x[g] + dx;
                    r_y[g+1] <= r_y[g] - dy;
                    r_z[g+1] <= r_z[g] + ATAN;
                end else begin
                    r_x[g+1] <= r_x[g] - dx;
                    r_y[g+1] <= r_y[g] + dy;
                    r_z[g+1] <= r_z[g] - ATAN;
                end
                r_zero[g+1] <= r_zero[g];
            end
        end
    end

    // Round to Q3.13 and clamp
    assign n_rnd = (r_z[STAGES] + 36'sd65536) >>> 17;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_zero[STAGES]) begin
                r_angle <= '0;
            end else if (n_rnd > ANGLE_LIMIT) begin
                r_angle <= 16'(ANGLE_LIMIT);
            end else if (n_rnd < -ANGLE_LIMIT) begin
                r_angle <= 16'(-ANGLE_LIMIT);
            end else begin
                r_angle <= 16'(n_rnd);
            end
        end
    end

    assign o_angle = r_angle;

endmodule
